FILE: design/cfc_pkg.sv
// ----------------------------------------------------------------------------
// cfc_pkg: shared types and constants for the single-to-custom float converter.
// Holds the field widths, the register indexes and the configuration struct.
// ----------------------------------------------------------------------------
package cfc_pkg;

	localparam int unsigned IEEE_W   = 32;
	localparam int unsigned PACKED_W = 34;
	localparam int unsigned MB_W     = 5;
	localparam int unsigned EB_W     = 4;
	localparam int unsigned CFG_W    = 5;
	localparam int unsigned IDX_W    = 2;

	// Register indexes of the configuration port.
	localparam logic [IDX_W-1:0] REG_MANTISSA_BITS = 2'd0;
	localparam logic [IDX_W-1:0] REG_EXPONENT_BITS = 2'd1;

	// Legal ranges and reset values of the two widths.
	localparam logic [MB_W-1:0] MB_MIN   = 5'd2;
	localparam logic [MB_W-1:0] MB_MAX   = 5'd23;
	localparam logic [MB_W-1:0] MB_RESET = 5'd16;
	localparam logic [EB_W-1:0] EB_MIN   = 4'd2;
	localparam logic [EB_W-1:0] EB_MAX   = 4'd10;
	localparam logic [EB_W-1:0] EB_RESET = 4'd6;

	// IEEE field constants.
	localparam logic [22:0] FRAC_MASK = 23'h7FFFFF;
	localparam logic [10:0] EXP_BIAS  = 11'd126;
	localparam logic [5:0]  DEFICIT_CAP = 6'd40;

	// Clamped format widths, as seen by the datapath.
	typedef struct packed {
		logic [MB_W-1:0] mant_bits;
		logic [EB_W-1:0] exp_bits;
	} cfc_cfg_t;

endpackage

FILE: design/float32_to_custom_float.sv
// ----------------------------------------------------------------------------
// float32_to_custom_float: IEEE single to custom float converter.
// Requests pass through one input register stage and one result register
// stage around the datapath; a stall on out_ready holds both stages.
// Throughput is one item per cycle while out_ready is high.
// Reset clears both stage valid bits and loads mantissa width 16, exponent
// width 6.
// ----------------------------------------------------------------------------
module float32_to_custom_float (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [cfc_pkg::IDX_W-1:0]    cfg_index,
	input  logic [cfc_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [cfc_pkg::IEEE_W-1:0]   ieee_bits,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [cfc_pkg::PACKED_W-1:0] packed_value,
	output logic                         exponent_wrapped
);
	import cfc_pkg::*;

	cfc_cfg_t            cfg;
	logic                valid_s1;
	logic [IEEE_W-1:0]   word_s1;
	logic                valid_s2;
	logic [PACKED_W-1:0] packed_s2;
	logic                wrapped_s2;
	logic [PACKED_W-1:0] conv_packed;
	logic                conv_wrapped;
	logic                adv_s2;

	cfc_config u_config (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	cfc_convert u_convert (
		.word         (word_s1),
		.cfg          (cfg),
		.packed_value (conv_packed),
		.wrapped      (conv_wrapped)
	);

	// Stage flow control: the result register moves when it is empty or taken.
	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			word_s1 <= ieee_bits;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			packed_s2  <= conv_packed;
			wrapped_s2 <= conv_wrapped;
		end
	end

	assign out_valid        = valid_s2;
	assign packed_value     = packed_s2;
	assign exponent_wrapped = wrapped_s2;

	// An empty result register always lets a new request in.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled while the result register is empty");

	// A zero request in the input stage yields an all-zero result.
	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s2 && valid_s1 && word_s1[30:0] == 31'd0)
		|=> (packed_value == '0 && !exponent_wrapped))
		else $error("zero request gave a nonzero result");

	// A wrapped exponent comes only with a nonzero result, never from zero.
	a_wrap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && exponent_wrapped) |-> (packed_value != '0))
		else $error("wrap flag on a zero result");

	// The stored widths never leave their legal ranges.
	a_cfg_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.mant_bits >= MB_MIN) && (cfg.mant_bits <= MB_MAX)
		&& (cfg.exp_bits >= EB_MIN) && (cfg.exp_bits <= EB_MAX))
		else $error("format width out of range");

endmodule

FILE: design/cfc_config.sv
// ----------------------------------------------------------------------------
// cfc_config: format width registers.
// Takes writes from the configuration port and stores the widths already
// clamped into their legal ranges.
// ----------------------------------------------------------------------------
module cfc_config (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [cfc_pkg::IDX_W-1:0] cfg_index,
	input  logic [cfc_pkg::CFG_W-1:0] cfg_wdata,
	output cfc_pkg::cfc_cfg_t        cfg
);
	import cfc_pkg::*;

	logic [MB_W-1:0] mb_q;
	logic [EB_W-1:0] eb_q;
	logic [MB_W-1:0] mb_clamped;
	logic [EB_W-1:0] eb_clamped;
	logic [EB_W-1:0] eb_raw;

	// Saturate the written values into the legal ranges; the exponent width uses only the low four bits of the write data.
	always_comb begin
		eb_raw = cfg_wdata[EB_W-1:0];
		if (cfg_wdata < MB_MIN) begin
			mb_clamped = MB_MIN;
		end else if (cfg_wdata > MB_MAX) begin
			mb_clamped = MB_MAX;
		end else begin
			mb_clamped = cfg_wdata;
		end
		if (eb_raw < EB_MIN) begin
			eb_clamped = EB_MIN;
		end else if (eb_raw > EB_MAX) begin
			eb_clamped = EB_MAX;
		end else begin
			eb_clamped = eb_raw;
		end
	end

	// Register writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mb_q <= MB_RESET;
			eb_q <= EB_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MANTISSA_BITS: mb_q <= mb_clamped;
				REG_EXPONENT_BITS: eb_q <= eb_clamped;
				default: ;
			endcase
		end
	end

	assign cfg.mant_bits = mb_q;
	assign cfg.exp_bits  = eb_q;

endmodule

FILE: design/cfc_convert.sv
// ----------------------------------------------------------------------------
// cfc_convert: conversion datapath.
// Unpacks the IEEE word, aligns the significand to the target width with
// underflow denormalization, rounds by the last dropped bit, renormalizes
// on a rounding carry and packs sign, exponent and mantissa.
// ----------------------------------------------------------------------------
module cfc_convert (
	input  logic [cfc_pkg::IEEE_W-1:0]   word,
	input  cfc_pkg::cfc_cfg_t            cfg,
	output logic [cfc_pkg::PACKED_W-1:0] packed_value,
	output logic                         wrapped
);
	import cfc_pkg::*;

	logic        sign;
	logic [23:0] sig;
	logic [10:0] e_raw;
	logic [10:0] half;
	logic [10:0] emin;
	logic [10:0] emax;
	logic        underflow;
	logic [10:0] deficit_full;
	logic [5:0]  deficit;
	logic [5:0]  shift;
	logic [23:0] m_trunc;
	logic [23:0] r_word;
	logic [24:0] m_round;
	logic        carry;
	logic [23:0] m_fin;
	logic [10:0] e_sel;
	logic [10:0] e_fin;
	logic [10:0] e_mask;
	logic [9:0]  efield;
	logic        is_zero;
	logic [MB_W:0] sum_w;

	always_comb begin
		sign    = word[31];
		sig     = {1'b1, word[22:0] & FRAC_MASK};
		is_zero = (word[30:0] == 31'd0);

		// Unbiased exponent for a mantissa that holds mant_bits bits.
		e_raw = {3'b000, word[30:23]} - EXP_BIAS - {6'b000000, cfg.mant_bits};

		// Exponent limits of the target field.
		half = 11'd1 << (cfg.exp_bits - 4'd1);
		emin = 11'd0 - half;
		emax = half - 11'd1;

		// Below the minimum the exponent is pinned and the mantissa shifts.
		underflow    = $signed(e_raw) < $signed(emin);
		deficit_full = emin - e_raw;
		if (!underflow) begin
			deficit = 6'd0;
		end else if (deficit_full > {5'd0, DEFICIT_CAP}) begin
			deficit = DEFICIT_CAP;
		end else begin
			deficit = deficit_full[5:0];
		end
		e_sel = underflow ? emin : e_raw;
		shift = (6'd24 - {1'b0, cfg.mant_bits}) + deficit;

		// Truncate and round by the last bit shifted out.
		m_trunc = sig >> shift;
		r_word  = sig >> (shift - 6'd1);
		m_round = {1'b0, m_trunc} + {24'd0, r_word[0]};

		// A carry into bit mant_bits renormalizes.
		carry = ((m_round >> cfg.mant_bits) != 25'd0);
		m_fin = carry ? m_round[24:1] : m_round[23:0];
		e_fin = e_sel + {10'd0, carry};

		// Wrap the exponent into its field.
		e_mask = (11'd1 << cfg.exp_bits) - 11'd1;
		efield = e_fin[9:0] & e_mask[9:0];

		// Pack sign, exponent and mantissa.
		sum_w = {1'b0, cfg.mant_bits} + {2'b00, cfg.exp_bits};
		if (is_zero) begin
			packed_value = '0;
			wrapped      = 1'b0;
		end else begin
			packed_value = (PACKED_W'(sign) << sum_w)
				| (PACKED_W'(efield) << cfg.mant_bits)
				| PACKED_W'(m_fin);
			wrapped      = $signed(e_fin) > $signed(emax);
		end
	end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the single-to-custom float converter.
// A short table of hand-picked words runs at the reset format. Random words
// follow under a series of formats, the extreme and saturating widths among
// them. Results are checked against an in-bench conversion routine or hand-worked
// values, and random back-pressure is applied on both channels except in one phase.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cfc_pkg::*;

	// Register indexes past the end of the register list; writes are dropped.
	localparam logic [IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [IDX_W-1:0] REG_SPARE_B = 2'd3;

	localparam int STALL_LIMIT  = 2000;
	localparam int WORDS_PER_FMT = 104;
	localparam int NUM_FORMATS  = 12;
	localparam int NUM_DIRECTED = 23;

	typedef struct packed {
		logic [PACKED_W-1:0] bits;
		logic                wrapped;
	} conv_t;

	typedef struct packed {
		logic [IEEE_W-1:0] word;
		conv_t             conv;
	} pack_entry_t;

	typedef struct packed {
		logic [IEEE_W-1:0]   word;
		logic                typed;
		logic [PACKED_W-1:0] bits;
		logic                wrapped;
	} dir_row_t;

	// Hand-picked words at the reset format (16-bit mantissa, 6-bit exponent).
	// Rows with typed set carry a result worked out by hand.
	localparam dir_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
		'{32'h0000_0000, 1'b1, 34'h0,      1'b0},	// positive zero
		'{32'h8000_0000, 1'b1, 34'h0,      1'b0},	// negative zero
		'{32'h3F80_0000, 1'b1, 34'h318000, 1'b0},	// 1.0
		'{32'hBF80_0000, 1'b1, 34'h718000, 1'b0},	// -1.0
		'{32'h7F7F_FFFF, 1'b1, 34'h318000, 1'b1},	// largest finite: carry, then wrap
		'{32'h0000_0001, 1'b1, 34'h200000, 1'b0},	// deep underflow rounds to zero
		'{32'h8000_0001, 1'b1, 34'h600000, 1'b0},	// same, sign kept
		'{32'h7F80_0000, 1'b0, 34'h0,      1'b0},	// infinity
		'{32'hFF80_0000, 1'b0, 34'h0,      1'b0},
		'{32'h7FC0_0000, 1'b0, 34'h0,      1'b0},	// NaN
		'{32'hFFFF_FFFF, 1'b0, 34'h0,      1'b0},
		'{32'h007F_FFFF, 1'b0, 34'h0,      1'b0},	// largest subnormal
		'{32'h0080_0000, 1'b0, 34'h0,      1'b0},	// smallest normal
		'{32'h3FFF_FFFF, 1'b0, 34'h0,      1'b0},	// rounding carry
		'{32'h3F80_8000, 1'b0, 34'h0,      1'b0},	// round bit clear
		'{32'h3F80_7F80, 1'b0, 34'h0,      1'b0},	// round bit set
		'{32'h3700_0000, 1'b0, 34'h0,      1'b0},	// exponent exactly at minimum
		'{32'h3680_0000, 1'b0, 34'h0,      1'b0},	// one below minimum
		'{32'h36FF_FFFF, 1'b0, 34'h0,      1'b0},	// underflow shift with carry
		'{32'h3FFF_FF80, 1'b0, 34'h0,      1'b0},
		'{32'hAAAA_AAAA, 1'b0, 34'h0,      1'b0},
		'{32'h5555_5555, 1'b0, 34'h0,      1'b0},
		'{32'h7FFF_FFFF, 1'b0, 34'h0,      1'b0}
	};

	// Register write data per format phase, saturating values included.
	localparam logic [CFG_W-1:0] FMT_MANT [NUM_FORMATS] =
		'{5'd2, 5'd23, 5'd23, 5'd2, 5'd0, 5'd31, 5'd1, 5'd24, 5'd8, 5'd0, 5'd0, 5'd0};
	localparam logic [CFG_W-1:0] FMT_EXP [NUM_FORMATS] =
		'{5'd2, 5'd10, 5'd2, 5'd10, 5'd0, 5'd15, 5'd17, 5'd11, 5'd4, 5'd0, 5'd0, 5'd0};

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]    cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic [IEEE_W-1:0]   ieee_bits;
	logic                out_valid;
	logic                out_ready;
	logic [PACKED_W-1:0] packed_value;
	logic                exponent_wrapped;

	// Bench copy of the format registers, as written.
	logic [MB_W-1:0] mant_reg;
	logic [EB_W-1:0] exp_reg;

	pack_entry_t pending_packs [$];
	pack_entry_t head;
	int          mismatches;
	int          stall_cycles;
	bit          steady;

	float32_to_custom_float u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.ieee_bits        (ieee_bits),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.packed_value     (packed_value),
		.exponent_wrapped (exponent_wrapped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Widths as the datapath sees them: saturated into the legal range.
	function automatic int eff_mant(input logic [MB_W-1:0] raw);
		if (raw < MB_MIN) return int'(MB_MIN);
		if (raw > MB_MAX) return int'(MB_MAX);
		return int'(raw);
	endfunction

	function automatic int eff_exp(input logic [EB_W-1:0] raw);
		if (raw < EB_MIN) return int'(EB_MIN);
		if (raw > EB_MAX) return int'(EB_MAX);
		return int'(raw);
	endfunction

	// Converts one IEEE word to the packed custom format.
	function automatic conv_t convert_single(input logic [IEEE_W-1:0] w,
			input logic [MB_W-1:0] mb_raw, input logic [EB_W-1:0] eb_raw);
		conv_t       res;
		int          mb;
		int          eb;
		int          e;
		int          emin;
		int          emax;
		int          shift;
		int          deficit;
		logic [63:0] sig;
		logic [63:0] m;
		logic [31:0] efield;
		logic [63:0] full;

		res = '0;
		// Both zeros pack to all zeros.
		if (w[30:0] == 31'd0) return res;

		mb   = eff_mant(mb_raw);
		eb   = eff_exp(eb_raw);
		emin = -(1 << (eb - 1));
		emax = (1 << (eb - 1)) - 1;
		sig  = {40'd0, 1'b1, w[22:0]};
		e    = int'(w[30:23]) - int'(EXP_BIAS) - mb;

		// Underflow: hold the exponent at its minimum and shift the deficit out.
		shift = 24 - mb;
		if (e < emin) begin
			deficit = emin - e;
			if (deficit > int'(DEFICIT_CAP)) deficit = int'(DEFICIT_CAP);
			shift = shift + deficit;
			e = emin;
		end

		// Round by adding the last dropped bit; a carry out renormalizes.
		m = (sig >> shift) + ((sig >> (shift - 1)) & 64'd1);
		if ((m >> mb) != 64'd0) begin
			m = m >> 1;
			e = e + 1;
		end

		res.wrapped = (e > emax);
		efield = 32'(e) & ((32'd1 << eb) - 32'd1);
		full = (64'(w[31]) << (mb + eb)) | (64'(efield) << mb) | m;
		res.bits = full[PACKED_W-1:0];
		return res;
	endfunction

	// Random word, weighted toward the exponent limits of the current format.
	function automatic logic [IEEE_W-1:0] pick_word(input logic [MB_W-1:0] mb_raw,
			input logic [EB_W-1:0] eb_raw);
		int          mb;
		int          eb;
		int          ex;
		int          kind;
		logic [22:0] frac;
		logic        s;

		mb   = eff_mant(mb_raw);
		eb   = eff_exp(eb_raw);
		s    = 1'($urandom_range(0, 1));
		frac = 23'($urandom);
		ex   = int'($urandom_range(0, 255));
		kind = int'($urandom_range(0, 99));

		if (kind < 35) return $urandom;
		else if (kind < 65) ex = 126 + mb - (1 << (eb - 1)) + int'($urandom_range(0, 9)) - 6;
		else if (kind < 85) ex = 126 + mb + (1 << (eb - 1)) - 1 + int'($urandom_range(0, 6)) - 3;
		else if (kind < 92) frac = 23'h7FFFFF - 23'($urandom_range(0, 3));
		else if (kind < 96) begin
			ex   = 0;
			frac = '0;
		end else begin
			ex = ($urandom_range(0, 1) != 0) ? 255 : 0;
		end

		if (ex < 0) ex = 0;
		if (ex > 255) ex = 255;
		return {s, 8'(ex), frac};
	endfunction

	task automatic note_mismatch(input string what, input logic [IEEE_W-1:0] w,
			input logic [PACKED_W-1:0] got, input logic [PACKED_W-1:0] want);
		mismatches++;
		if (mismatches <= 50)
			$display("MISMATCH %s, request 0x%08h: got 0x%09h, wanted 0x%09h",
				what, w, got, want);
	endtask

	// Offers one request, with random gaps ahead of it unless steady, and records its expected result.
	task automatic push_request(input logic [IEEE_W-1:0] w, input bit typed,
			input conv_t typed_conv);
		conv_t want;

		while (!steady && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		ieee_bits <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		want = typed ? typed_conv : convert_single(w, mant_reg, exp_reg);
		pending_packs.push_back('{w, want});
	endtask

	// Stops requests and waits until every result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_packs.size() != 0) @(posedge clk);
	endtask

	// Writes both widths, then one write to an unused index that must be dropped.
	task automatic set_format(input logic [CFG_W-1:0] mb_data,
			input logic [CFG_W-1:0] eb_data, input logic [IDX_W-1:0] spare_idx);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_MANTISSA_BITS;
		cfg_wdata <= mb_data;
		@(posedge clk);
		mant_reg  = mb_data[MB_W-1:0];
		cfg_index <= REG_EXPONENT_BITS;
		cfg_wdata <= eb_data;
		@(posedge clk);
		exp_reg   = eb_data[EB_W-1:0];
		cfg_index <= spare_idx;
		cfg_wdata <= CFG_W'($urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Stimulus: directed table, then random words under each format.
	initial begin
		conv_t            row_conv;
		logic [CFG_W-1:0] mb_data;
		logic [CFG_W-1:0] eb_data;

		arst_n     = 1'b0;
		cfg_wr_en  = 1'b0;
		cfg_index  = REG_MANTISSA_BITS;
		cfg_wdata  = '0;
		in_valid   = 1'b0;
		ieee_bits  = '0;
		mant_reg   = MB_RESET;
		exp_reg    = EB_RESET;
		mismatches = 0;
		steady     = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[i]) begin
			row_conv.bits    = DIRECTED_ROWS[i].bits;
			row_conv.wrapped = DIRECTED_ROWS[i].wrapped;
			push_request(DIRECTED_ROWS[i].word, DIRECTED_ROWS[i].typed, row_conv);
		end
		drain_results();

		for (int p = 0; p < NUM_FORMATS; p++) begin
			mb_data = FMT_MANT[p];
			eb_data = FMT_EXP[p];
			// The last phases pick their widths at random.
			if (p >= 9) begin
				mb_data = CFG_W'($urandom);
				eb_data = CFG_W'($urandom);
			end
			set_format(mb_data, eb_data, (p % 2 == 0) ? REG_SPARE_A : REG_SPARE_B);
			// One phase runs with no gaps on either channel.
			steady = (p == 5);
			for (int i = 0; i < WORDS_PER_FMT; i++)
				push_request(pick_word(mant_reg, exp_reg), 1'b0, '0);
			drain_results();
		end
		steady = 1'b0;

		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Result checker and random result back-pressure.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_packs.size() == 0) begin
				note_mismatch("unexpected result", '0, packed_value, '0);
			end else begin
				head = pending_packs.pop_front();
				if (packed_value !== head.conv.bits)
					note_mismatch("packed_value", head.word, packed_value, head.conv.bits);
				if (exponent_wrapped !== head.conv.wrapped)
					note_mismatch("exponent_wrapped", head.word,
						PACKED_W'(exponent_wrapped), PACKED_W'(head.conv.wrapped));
			end
		end
		out_ready <= steady || ($urandom_range(0, 99) >= 8);
	end

	// Watchdog: ends the run when no request or result moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		stall_cycles = 0;
		out_ready    = 1'b0;
	end

endmodule

FILE: float32_to_custom_float.f
design/cfc_pkg.sv
design/cfc_config.sv
design/cfc_convert.sv
design/float32_to_custom_float.sv
tb/tb_top.sv
